// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, character codes, request/result structs, controller state,
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = 8;
  localparam int ROW_W  = 6;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 2 * CHAR_W;

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] MOVE_END  = ADDR_W'(CELLS - COLS);
  localparam logic [COL_W-1:0]  COLS_C    = COL_W'(COLS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROWS_R    = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BKSP    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ERROR   = 8'h45;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;
  localparam logic [CHAR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [CHAR_W-1:0] ERROR_ATTR_RST   = 8'd4;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_BKSP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic {
    FILL_ZERO  = 1'b0,
    FILL_SPACE = 1'b1
  } fill_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_EXEC,
    ST_MOVE,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] attr;
    logic              use_cursor;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } tcw_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  next_col;
    logic [ROW_W-1:0]  next_row;
    logic              range_error;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } tcw_out_t;

  // Controller to datapath
  typedef struct packed {
    logic  capture;
    logic  calc;
    logic  exec;
    logic  move;
    logic  fill;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  fill_load;
    fill_e fill_kind;
    logic  out_load;
  } tcw_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic scroll;
    logic move_last;
    logic cnt_last;
  } tcw_stat_t;

endpackage

// ===== sv/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp: text console writer datapath
// Cell RAM, cursor, configuration registers, address calculation, sweep
// counter for scroll/clear, and the result register.
// ----------------------------------------------------------------------------
module tcw_dp import tcw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CHAR_W-1:0]    cfg_wdata_i,
  input  tcw_in_t              in_data_i,
  output tcw_out_t             out_data_o,
  input  tcw_ctrl_t            ctrl_i,
  output tcw_stat_t            stat_o
);

  tcw_in_t             item_q;
  logic [CHAR_W-1:0]   def_attr_q, err_attr_q;
  logic [COL_W-1:0]    cur_col_q, cur_col_d;
  logic [ROW_W-1:0]    cur_row_q, cur_row_d;
  logic [COL_W-1:0]    pos_col_q, sel_col, bs_col, adv_col;
  logic [ROW_W-1:0]    pos_row_q, sel_row, bs_row, adv_row;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [ADDR_W-1:0]   cnt_q;
  logic [CELL_W-1:0]   fill_q;
  logic [CELL_W-1:0]   mem_q [CELLS];
  logic [CELL_W-1:0]   rdata_q;
  tcw_out_t            out_q;
  logic                err, newline, wrap, bs_ok;
  logic [CHAR_W-1:0]   attr_eff;
  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [CELL_W-1:0]   wdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= DEFAULT_ATTR_RST;
      err_attr_q <= ERROR_ATTR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEFAULT_ATTR: def_attr_q <= cfg_wdata_i;
        REG_ERROR_ATTR:   err_attr_q <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // Request decode
  assign err = !item_q.use_cursor &&
               (item_q.cmd == CMD_PUT || item_q.cmd == CMD_READ) &&
               (item_q.col >= COLS_C || item_q.row >= ROWS_R);
  assign newline  = (item_q.ch == CH_NEWLINE);
  assign attr_eff = (item_q.attr == '0) ? def_attr_q : item_q.attr;
  assign bs_ok    = (cur_col_q != '0) || (cur_row_q != '0);

  // Target position: cell behind the cursor, the cursor, or the given one
  always_comb begin
    bs_col = (cur_col_q == '0) ? LAST_COL : cur_col_q - 1'b1;
    bs_row = (cur_col_q == '0) ? cur_row_q - 1'b1 : cur_row_q;
    if (item_q.cmd == CMD_BKSP) begin
      sel_col = bs_col;
      sel_row = bs_row;
    end else if (item_q.use_cursor) begin
      sel_col = cur_col_q;
      sel_row = cur_row_q;
    end else begin
      sel_col = item_q.col;
      sel_row = item_q.row;
    end
    addr_d = err ? LAST_CELL : ADDR_W'(sel_row) * COLS_A + ADDR_W'(sel_col);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.calc) begin
      pos_col_q <= sel_col;
      pos_row_q <= sel_row;
      addr_q    <= addr_d;
    end
  end

  // Position after a put
  assign wrap    = newline || (pos_col_q == LAST_COL);
  assign adv_col = wrap ? '0 : pos_col_q + 1'b1;
  assign adv_row = wrap ? pos_row_q + 1'b1 : pos_row_q;

  // Cursor
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (ctrl_i.exec) begin
      if (item_q.cmd == CMD_CLEAR) begin
        cur_col_d = '0;
        cur_row_d = '0;
      end else if (item_q.cmd == CMD_PUT && !err) begin
        cur_col_d = adv_col;
        cur_row_d = (adv_row == ROWS_R) ? LAST_ROW : adv_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

  // Sweep counter and fill pattern; reset starts the zeroing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fill_q <= '0;
    end else begin
      if (ctrl_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (ctrl_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl_i.fill_load) begin
        fill_q <= (ctrl_i.fill_kind == FILL_SPACE) ? {def_attr_q, CH_SPACE} : '0;
      end
    end
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = addr_q;
    raddr = addr_q;
    wdata = '0;
    if (ctrl_i.exec) begin
      unique case (item_q.cmd)
        CMD_PUT: begin
          if (err) begin
            we    = 1'b1;
            wdata = {err_attr_q, CH_ERROR};
          end else begin
            we    = !newline;
            wdata = {attr_eff, item_q.ch};
          end
        end
        CMD_BKSP: begin
          we    = bs_ok;
          wdata = {def_attr_q, CH_BKSP};
        end
        CMD_READ:  re = !err;
        CMD_CLEAR: ;
      endcase
    end else if (ctrl_i.move) begin
      // read one row ahead, write the word read in the previous cycle
      re    = (cnt_q != MOVE_END);
      raddr = cnt_q + COLS_A;
      we    = (cnt_q != '0);
      waddr = cnt_q - 1'b1;
      wdata = rdata_q;
    end else if (ctrl_i.fill) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = fill_q;
    end
  end

  // Cell RAM, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q.next_col    <= err ? item_q.col : cur_col_q;
      out_q.next_row    <= err ? item_q.row : cur_row_q;
      out_q.range_error <= err;
      if (item_q.cmd == CMD_READ && !err) begin
        out_q.cell_char <= rdata_q[CHAR_W-1:0];
        out_q.cell_attr <= rdata_q[CELL_W-1:CHAR_W];
      end else begin
        out_q.cell_char <= '0;
        out_q.cell_attr <= '0;
      end
    end
  end

  assign out_data_o = out_q;

  // Status
  assign stat_o.is_clear  = (item_q.cmd == CMD_CLEAR);
  assign stat_o.scroll    = (item_q.cmd == CMD_PUT) && !err && (adv_row == ROWS_R);
  assign stat_o.move_last = (cnt_q == MOVE_END);
  assign stat_o.cnt_last  = (cnt_q == LAST_CELL);

endmodule

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl: text console writer controller
// Sequences each request through address calculation, execution, the
// scroll/clear sweeps and the result handoff; owns the handshakes.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tcw_ctrl_t ctrl_o,
  input  tcw_stat_t stat_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        ctrl_o.fill    = 1'b1;
        ctrl_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_CALC;
        end
      end
      ST_CALC: begin
        ctrl_o.calc = 1'b1;
        state_d     = ST_EXEC;
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        if (stat_i.is_clear) begin
          ctrl_o.fill_load = 1'b1;
          ctrl_o.fill_kind = FILL_SPACE;
          ctrl_o.cnt_clr   = 1'b1;
          state_d          = ST_FILL;
        end else if (stat_i.scroll) begin
          ctrl_o.cnt_clr = 1'b1;
          state_d        = ST_MOVE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MOVE: begin
        ctrl_o.move = 1'b1;
        if (stat_i.move_last) begin
          // counter already sits on the first cell of the last row
          ctrl_o.fill_load = 1'b1;
          ctrl_o.fill_kind = FILL_ZERO;
          state_d          = ST_FILL;
        end else begin
          ctrl_o.cnt_inc = 1'b1;
        end
      end
      ST_FILL: begin
        ctrl_o.fill    = 1'b1;
        ctrl_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on load, cleared when taken
  assign out_valid_d = ctrl_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top: text-mode console engine
// ROWS x COLS cell RAM of character/attribute pairs with a cursor; put,
// clear, backspace and read-cell requests, one result per request.
//
//   channel  signals                          direction
//   in       in_valid_i/in_ready_o/in_data_i  request in
//   out      out_valid_o/out_ready_i/out_data_o  result out
//   cfg      cfg_we_i/cfg_idx_i/cfg_wdata_i   register write
//
// Put, backspace and read pass through the CALC, EXEC and DONE states; DONE
// loads the result once any earlier one is taken, one request at a time. A
// put that leaves the last row first copies the rows up through the single
// read and write port of the cell RAM, then zeroes the last row; clear
// refills every cell. After reset a zeroing pass over every cell holds
// in_ready_o low; register writes are taken throughout.
// A finished result waits in the output register until taken.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CHAR_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcw_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tcw_out_t             out_data_o
);

  tcw_ctrl_t ctrl;
  tcw_stat_t stat;

  // Sequencer
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  // Cell RAM, cursor and result path
  tcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

// ===== sv/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Result hold under stall, result consistency and request spacing.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input tcw_out_t             out_data_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Error results carry no cell contents
  a_err_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |->
      out_data_o.cell_char == '0 && out_data_o.cell_attr == '0)
    else $error("range error result with cell data");

  // Error flag matches an off-screen reported position
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.range_error ==
      (out_data_o.next_col >= COLS_C || out_data_o.next_row >= ROWS_R))
    else $error("reported position and range error disagree");

  // One request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the previous one is in progress");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);
